### rtl/satq_pkg.sv
// ----------------------------------------------------------------------------
// satq_pkg
// Types and constants shared by the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package satq_pkg;

  // input command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // result kind codes
  localparam logic KIND_EXPIRED  = 1'b0;
  localparam logic KIND_REJECTED = 1'b1;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        cmd;
    logic [15:0] delay_seconds;
    logic [15:0] alarm_tag;
  } satq_in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] expired_delay;
    logic [15:0] expired_tag;
    logic        last;
  } satq_out_t;

  // one queue entry as held in the entry RAM
  typedef struct packed {
    logic [31:0] expiry;
    logic [15:0] delay;
    logic [15:0] tag;
  } satq_entry_t;

endpackage

### rtl/satq_ram.sv
// ----------------------------------------------------------------------------
// satq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module satq_ram #(
  parameter int Width = 64,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sorted_alarm_timer_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue_core
// Bounded alarm queue kept sorted by absolute expiry. Inserts place an alarm
// before all entries with equal or later expiry; ticks advance the seconds
// counter and drain every entry that has come due.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o    | in_item_i  (satq_in_t)
//  out     | output    | out_valid_o / out_ready_i  | out_item_o (satq_out_t)
//
//  Insert: walks from the tail, moving each entry with equal or later expiry
//    back one slot, then writes the new entry. Tick: time advances; due
//    entries then pop from the head, the final one marked last. One RAM
//    read port, one write port and one comparator set the pace.
//  A full-queue insert yields one rejected item from the idle state.
//  Output stalls hold the drain in place; no new item is taken until the
//    sequencer is back in idle and the output register is free.
//  Reset clears time, occupancy and head; the entry RAM needs no clearing.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue_core
  import satq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  satq_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output satq_out_t out_item_o
);

  localparam int AW = $clog2(CAPACITY);      // RAM address width
  localparam int CW = $clog2(CAPACITY + 1);  // occupancy width
  localparam int PW = AW + 1;                // wrap sum width

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_CMP = 3'd1;  // compare one entry, move it back or place the new one
  localparam logic [2:0] ST_INS_PUT = 3'd2;  // write the new entry at slot 0
  localparam logic [2:0] ST_TK_CMP  = 3'd3;  // check head entry against time
  localparam logic [2:0] ST_TK_FLSH = 3'd4;  // emit the held item as last

  // logical slot -> physical RAM address in the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [PW-1:0] s;
    s = PW'(base) + PW'(off);
    if (s >= PW'(CAPACITY)) begin
      s = s - PW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]    state_q, state_d;
  logic [31:0]   now_q, now_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] idx_q, idx_d;        // logical slot being filled on insert
  logic [31:0]   exp_q, exp_d;
  logic [15:0]   dly_q, dly_d;
  logic [15:0]   tag_q, tag_d;
  logic          pend_q, pend_d;      // a due item waits for its last flag
  logic [15:0]   pdly_q, pdly_d;
  logic [15:0]   ptag_q, ptag_d;
  logic          out_valid_q, out_valid_d;
  satq_out_t     out_item_q, out_item_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  satq_entry_t   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [$bits(satq_entry_t)-1:0] ram_rdata;
  satq_entry_t   rd_entry;

  logic          out_free;
  logic          accept;
  logic [32:0]   exp_sum;
  logic [31:0]   exp_sat;
  logic [AW-1:0] head_next;

  // shared magnitude comparator
  logic [31:0]   cmp_a, cmp_b;
  logic          cmp_lt;

  assign rd_entry  = satq_entry_t'(ram_rdata);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept    = in_valid_i && in_ready_o;
  assign exp_sum   = {1'b0, now_q} + 33'(in_item_i.delay_seconds);
  assign exp_sat   = exp_sum[32] ? TIME_MAX : exp_sum[31:0];
  assign head_next = phys(head_q, CW'(1));

  // insert: is the stored entry earlier than the new one?
  // tick:   is the current time earlier than the head entry?
  always_comb begin
    if (state_q == ST_INS_CMP) begin
      cmp_a = rd_entry.expiry;
      cmp_b = exp_q;
    end else begin
      cmp_a = now_q;
      cmp_b = rd_entry.expiry;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    occ_d       = occ_q;
    head_d      = head_q;
    idx_d       = idx_q;
    exp_d       = exp_q;
    dly_d       = dly_q;
    tag_d       = tag_q;
    pend_d      = pend_q;
    pdly_d      = pdly_q;
    ptag_d      = ptag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    ram_we      = 1'b0;
    ram_waddr   = phys(head_q, CW'(idx_q));
    ram_wdata   = '{expiry: exp_q, delay: dly_q, tag: tag_q};
    ram_raddr   = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.cmd == CMD_INSERT) begin
            dly_d = in_item_i.delay_seconds;
            tag_d = in_item_i.alarm_tag;
            exp_d = exp_sat;
            if (occ_q == CW'(CAPACITY)) begin
              out_valid_d = 1'b1;
              out_item_d  = '{kind: KIND_REJECTED,
                              expired_delay: in_item_i.delay_seconds,
                              expired_tag: in_item_i.alarm_tag,
                              last: 1'b1};
            end else if (occ_q == '0) begin
              idx_d   = '0;
              state_d = ST_INS_PUT;
            end else begin
              idx_d     = occ_q[AW-1:0];
              ram_raddr = phys(head_q, occ_q - CW'(1));
              state_d   = ST_INS_CMP;
            end
          end else begin
            now_d = (now_q == TIME_MAX) ? TIME_MAX : now_q + 32'd1;
            if (occ_q != '0) begin
              state_d = ST_TK_CMP;
            end
          end
        end
      end

      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (!cmp_lt) begin
          // stored entry expires at or after the new one: move it back
          ram_wdata = rd_entry;
          idx_d     = idx_q - AW'(1);
          if (idx_q == AW'(1)) begin
            state_d = ST_INS_PUT;
          end else begin
            ram_raddr = phys(head_q, CW'(idx_q) - CW'(2));
          end
        end else begin
          occ_d   = occ_q + CW'(1);
          state_d = ST_IDLE;
        end
      end

      ST_INS_PUT: begin
        ram_we  = 1'b1;
        occ_d   = occ_q + CW'(1);
        state_d = ST_IDLE;
      end

      ST_TK_CMP: begin
        if (!cmp_lt) begin
          // head is due; the previous due item goes out without last
          if (!pend_q || out_free) begin
            if (pend_q) begin
              out_valid_d = 1'b1;
              out_item_d  = '{kind: KIND_EXPIRED, expired_delay: pdly_q,
                              expired_tag: ptag_q, last: 1'b0};
            end
            pend_d = 1'b1;
            pdly_d = rd_entry.delay;
            ptag_d = rd_entry.tag;
            head_d = head_next;
            occ_d  = occ_q - CW'(1);
            ram_raddr = head_next;
            if (occ_q == CW'(1)) begin
              state_d = ST_TK_FLSH;
            end
          end
        end else begin
          state_d = ST_TK_FLSH;
        end
      end

      ST_TK_FLSH: begin
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '{kind: KIND_EXPIRED, expired_delay: pdly_q,
                          expired_tag: ptag_q, last: 1'b1};
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      occ_q       <= '0;
      head_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      occ_q       <= occ_d;
      head_q      <= head_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    exp_q      <= exp_d;
    dly_q      <= dly_d;
    tag_q      <= tag_d;
    pdly_q     <= pdly_d;
    ptag_q     <= ptag_d;
    out_item_q <= out_item_d;
  end

  satq_ram #(
    .Width ($bits(satq_entry_t)),
    .Depth (CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("ready outside idle");

  a_pend_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_TK_CMP || state_q == ST_TK_FLSH))
    else $error("held item outside tick drain");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.kind == KIND_REJECTED)
      |-> (out_item_o.last && occ_q == CW'(CAPACITY)))
    else $error("reject without full queue");

  a_shift_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_CMP) |-> (idx_q != '0))
    else $error("insert compare at slot zero");

endmodule

### tb/sv/sorted_alarm_timer_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue_core_tb
// Drives inserts and ticks into the alarm queue and predicts every expired
// and rejected item. Both channels idle and stall at random. One long output
// hold backs the queue up into its input, and the sender drains between phases.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue_core_tb;
  import satq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE       = 40;    // longer than the worst insert walk
  localparam int STALL_LIMIT  = 4000;  // cycles with no item moving either way
  localparam int IDLE_PCT     = 7;

  // --------------------------------------------------------------------------
  // Alarm queue scoreboard: mirrors time and the sorted entry list, and keeps
  // the results still owed by the block in arrival order.
  // --------------------------------------------------------------------------
  class alarm_scoreboard;
    logic [31:0]  now_s = '0;
    satq_entry_t  alarms[$];
    satq_out_t    owed[$];
    int           errors     = 0;
    int           n_rejected = 0;
    int           max_burst  = 0;

    function void note_accepted(satq_in_t it);
      logic [32:0] sum;
      satq_entry_t ent;
      satq_out_t   res;
      int          pos;
      int          n;
      if (it.cmd == CMD_INSERT) begin
        if (alarms.size() >= QUEUE_DEPTH) begin
          res.kind          = KIND_REJECTED;
          res.expired_delay = it.delay_seconds;
          res.expired_tag   = it.alarm_tag;
          res.last          = 1'b1;
          owed.push_back(res);
          n_rejected++;
        end else begin
          sum = {1'b0, now_s} + {17'd0, it.delay_seconds};
          ent.expiry = sum[32] ? TIME_MAX : sum[31:0];
          ent.delay  = it.delay_seconds;
          ent.tag    = it.alarm_tag;
          // new entry goes ahead of equal expiries: ties drain newest first
          pos = 0;
          while (pos < alarms.size() && alarms[pos].expiry < ent.expiry) pos++;
          alarms.insert(pos, ent);
        end
      end else begin
        if (now_s != TIME_MAX) now_s++;
        n = 0;
        while (alarms.size() > 0 && alarms[0].expiry <= now_s) begin
          ent               = alarms.pop_front();
          res.kind          = KIND_EXPIRED;
          res.expired_delay = ent.delay;
          res.expired_tag   = ent.tag;
          res.last          = 1'b0;
          owed.push_back(res);
          n++;
        end
        if (n > 0) owed[owed.size() - 1].last = 1'b1;
        if (n > max_burst) max_burst = n;
      end
    endfunction

    function void field_cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(satq_out_t got);
      satq_out_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      field_cmp("kind", 16'(want.kind), 16'(got.kind));
      field_cmp("expired_delay", want.expired_delay, got.expired_delay);
      field_cmp("expired_tag", want.expired_tag, got.expired_tag);
      field_cmp("last", 16'(want.last), 16'(got.last));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready_o;
  satq_in_t  in_item;
  logic      out_valid_o;
  logic      out_ready;
  satq_out_t out_item_o;

  alarm_scoreboard sb = new();

  bit gaps_on   = 1'b1;  // random idling on both channels
  bit hold_req  = 1'b0;  // asks the receiver for one long hold-off
  int n_items   = 0;
  int n_results = 0;
  int quiet     = 0;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  sorted_alarm_timer_queue_core #(
    .CAPACITY (QUEUE_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  // --------------------------------------------------------------------------
  // Output side: the monitor samples at the edge, before any NBA of that edge
  // lands, so it sees exactly what the DUT saw. Ready is driven separately.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      sb.check_result(out_item_o);
      n_results++;
    end
  end

  initial begin
    out_ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long hold: the queue backs up and in_ready must drop
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (gaps_on) begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("[sorted_alarm_timer_queue_core] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offers one item and returns at the edge that accepts it. Valid is left
  // high so a back-to-back item only swaps the payload.
  task automatic send_item(input satq_in_t it);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_accepted(it);
    n_items++;
  endtask

  task automatic send_fields(input logic cmd, input logic [15:0] dly,
                             input logic [15:0] tg);
    satq_in_t it;
    it.cmd           = cmd;
    it.delay_seconds = dly;
    it.alarm_tag     = tg;
    send_item(it);
  endtask

  // Sender pause: nothing offered until every owed result is back, then a
  // margin for an insert that may still be walking the entry RAM.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Mostly short delays so alarms come due; a few full-range ones that
  // stay parked. Tick items carry random junk in the unused fields.
  function automatic satq_in_t rand_item(int tick_pct, int max_delay);
    satq_in_t it;
    it.alarm_tag = 16'($urandom);
    if ($urandom_range(99) < tick_pct) begin
      it.cmd           = CMD_TICK;
      it.delay_seconds = 16'($urandom);
    end else begin
      it.cmd = CMD_INSERT;
      if ($urandom_range(99) < 3) it.delay_seconds = 16'($urandom);
      else                        it.delay_seconds = 16'($urandom_range(max_delay));
    end
    return it;
  endfunction

  task automatic send_random(int count, int tick_pct, int max_delay);
    repeat (count) send_item(rand_item(tick_pct, max_delay));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tick on empty queue, zero delay, equal-expiry ordering
    send_fields(CMD_TICK,   16'h0000, 16'h0000);   // nothing due
    send_fields(CMD_INSERT, 16'h0000, 16'hFFFF);   // due on next tick
    send_fields(CMD_INSERT, 16'h0002, 16'hAAAA);
    send_fields(CMD_INSERT, 16'h0002, 16'h5555);   // same expiry, drains first
    send_fields(CMD_TICK,   16'hFFFF, 16'hFFFF);
    send_fields(CMD_TICK,   16'h1234, 16'h4321);
    // fill to capacity, reject one, then drain all sixteen in one tick
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_fields(CMD_INSERT, 16'h0001, 16'(16'h0100 + i));
    send_fields(CMD_INSERT, 16'hFFFF, 16'h0000);   // queue full: rejected
    send_fields(CMD_TICK,   16'h0000, 16'h0000);
    send_fields(CMD_INSERT, 16'hFFFF, 16'h8001);   // parked for good
    drain_results();

    // mixed traffic with random idling
    send_random(100, 50, 12);

    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    send_random(40, 50, 3);
    drain_results();

    // a stretch with no idling on either side
    gaps_on = 1'b0;
    send_random(80, 45, 10);
    drain_results();
    gaps_on = 1'b1;

    // insert-heavy burst toward a full queue, then a tick-heavy run to drain due alarms
    send_random(20, 10, 4);
    send_random(15, 90, 4);

    drain_results();

    $display("%0d items in, %0d results out (%0d rejected inserts)",
             n_items, n_results, sb.n_rejected);
    $display("largest single-tick drain: %0d alarms, %0d left parked",
             sb.max_burst, sb.alarms.size());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[sorted_alarm_timer_queue_core] OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("[sorted_alarm_timer_queue_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/satq_pkg.sv
rtl/satq_ram.sv
rtl/sorted_alarm_timer_queue_core.sv
tb/sv/sorted_alarm_timer_queue_core_tb.sv
